>>> sv/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

  // Result kinds carried on the result channel.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Protocol error codes, in the order they are checked.
  localparam logic [1:0] ERR_TOO_LONG   = 2'd0;
  localparam logic [1:0] ERR_MASK       = 2'd1;
  localparam logic [1:0] ERR_FRAGMENTED = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEER    = 2'd1;

  // Header constants.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  // Result channel data width: byte, opcode, length and error code, padded to bytes.
  localparam int unsigned OUT_DATA_W = 48;

  // One result item handed from the parser to the output register.
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  opcode;
    logic [31:0] length;
    logic        eof;
    logic [1:0]  error_code;
  } wsd_result_t;

  // Live configuration seen by the parser.
  typedef struct packed {
    logic [31:0] max_len;
    logic        peer_is_client;
  } wsd_cfg_t;

endpackage

>>> sv/wsd_parser.sv
`timescale 1ns / 1ps

module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  byte_in,
  input  wsd_cfg_t    cfg,
  output wsd_result_t result
);

  // Parse phases.
  localparam logic [2:0] PH_B0   = 3'd0;
  localparam logic [2:0] PH_B1   = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_DEAD = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        long_r, long_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [1:0]  pos_r, pos_nxt;

  logic        decide;
  logic        hdr_done;
  logic        ext_done;
  logic        too_long;
  logic        mask_bad;
  logic        frag_bad;
  logic [7:0]  key_byte;

  // Next-state and result decode for one stream byte.
  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    long_nxt   = long_r;
    key_nxt    = key_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    decide     = 1'b0;
    hdr_done   = 1'b0;
    ext_done   = 1'b0;
    too_long   = 1'b0;
    mask_bad   = 1'b0;
    frag_bad   = 1'b0;
    key_byte   = 8'd0;
    result     = '0;

    case (phase_r)
      PH_B0: begin
        fin_nxt    = byte_in[7];
        opcode_nxt = byte_in[3:0];
        key_nxt    = 32'd0;
        acc_nxt    = 64'd0;
        rem_nxt    = 32'd0;
        pos_nxt    = 2'd0;
        phase_nxt  = PH_B1;
      end
      PH_B1: begin
        masked_nxt = byte_in[7];
        if ((byte_in[6:0] == LEN_EXT16) || (byte_in[6:0] == LEN_EXT64)) begin
          long_nxt  = (byte_in[6:0] == LEN_EXT64);
          acc_nxt   = 64'd0;
          cnt_nxt   = 3'd0;
          phase_nxt = PH_EXT;
        end else begin
          acc_nxt = {57'd0, byte_in[6:0]};
          decide  = 1'b1;
        end
      end
      PH_EXT: begin
        acc_nxt  = {acc_r[55:0], byte_in};
        cnt_nxt  = cnt_r + 3'd1;
        ext_done = long_r ? (cnt_nxt == 3'd0) : (cnt_nxt == 3'd2);
        decide   = ext_done;
      end
      PH_MASK: begin
        key_nxt  = {key_r[23:0], byte_in};
        cnt_nxt  = cnt_r + 3'd1;
        hdr_done = (cnt_nxt == 3'd4);
      end
      PH_DATA: begin
        // Key byte zero sits in the top byte of the key register.
        key_byte = key_r[{~pos_r, 3'b000} +: 8];
        pos_nxt  = pos_r + 2'd1;
        rem_nxt  = rem_r - 32'd1;
        result.valid        = 1'b1;
        result.kind         = KIND_PAYLOAD;
        result.payload_byte = byte_in ^ key_byte;
        result.opcode       = opcode_r;
        result.length       = acc_r[31:0];
        result.eof          = (rem_r == 32'd1);
        if (rem_r == 32'd1) begin
          phase_nxt = PH_B0;
        end
      end
      default: begin
        phase_nxt = PH_DEAD;
      end
    endcase

    // Error checks once the payload length is fully known.
    if (decide) begin
      too_long = (|acc_nxt[63:32]) || (acc_nxt[31:0] > cfg.max_len);
      mask_bad = (masked_nxt != cfg.peer_is_client);
      frag_bad = !fin_r && !(opcode_r inside {OP_CONT, OP_CLOSE, OP_PING, OP_PONG});
      if (too_long || mask_bad || frag_bad) begin
        phase_nxt         = PH_DEAD;
        result.valid      = 1'b1;
        result.kind       = KIND_ERROR;
        result.opcode     = opcode_r;
        result.length     = acc_nxt[31:0];
        result.eof        = 1'b0;
        result.error_code = too_long ? ERR_TOO_LONG : (mask_bad ? ERR_MASK : ERR_FRAGMENTED);
      end else if (masked_nxt) begin
        cnt_nxt   = 3'd0;
        phase_nxt = PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: either an empty frame or the start of the payload.
    if (hdr_done) begin
      pos_nxt = 2'd0;
      if (acc_nxt[31:0] == 32'd0) begin
        phase_nxt     = PH_B0;
        result.valid  = 1'b1;
        result.kind   = KIND_EMPTY;
        result.opcode = opcode_r;
        result.length = 32'd0;
        result.eof    = 1'b1;
      end else begin
        rem_nxt   = acc_nxt[31:0];
        phase_nxt = PH_DATA;
      end
    end
  end

  // Parser state advances only when a byte is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_B0;
      fin_r    <= 1'b0;
      opcode_r <= 4'd0;
      masked_r <= 1'b0;
      acc_r    <= 64'd0;
      cnt_r    <= 3'd0;
      long_r   <= 1'b0;
      key_r    <= 32'd0;
      rem_r    <= 32'd0;
      pos_r    <= 2'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      long_r   <= long_nxt;
      key_r    <= key_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule

>>> sv/websocket_frame_deframer.sv
`timescale 1ns / 1ps

// WebSocket receive-side frame deframer.
// The input channel (in_*) carries the raw stream, one byte per transaction.
// The result channel (out_*) carries at most one result per input byte: an
// unmasked payload byte, an empty-frame marker, or a protocol error. tlast
// marks the last result of a frame; tuser holds the result kind.
// Configuration (cfg_*) writes the maximum payload length (index 0) and the
// masking role (index 1); write it only while no transaction is in flight.
// Throughput is one byte per cycle while out_tready stays high. A byte goes
// from the input register through the parser logic into the output register,
// which holds its result until the receiver takes it.
// When the receiver holds out_tready low, the output register holds its
// result and the input register fills; in_tready drops once both are full.
// After a protocol error the block discards all further bytes until reset.
// Reset returns the parser to the first header byte, empties both
// registers and restores the configuration defaults.

module websocket_frame_deframer import wsd_pkg::*; #(
  parameter logic [31:0] MAX_LEN_RESET = 32'd65536,
  parameter logic        PEER_RESET    = 1'b1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] in_byte
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] payload_byte, [11:8] frame_opcode,
                                            // [43:12] frame_length, [45:44] error_code,
                                            // [47:46] zero
  output logic                  out_tlast,  // end_of_frame
  output logic [1:0]            out_tuser,  // [1:0] result_kind
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        step;
  wsd_cfg_t    cfg_r;
  wsd_result_t result;

  logic        out_valid_r;
  wsd_result_t out_r;

  // A buffered byte is consumed whenever the output register has room.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_len        <= MAX_LEN_RESET;
      cfg_r.peer_is_client <= PEER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_LEN: cfg_r.max_len        <= cfg_data;
        CFG_PEER:    cfg_r.peer_is_client <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  wsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_byte_r),
    .cfg     (cfg_r),
    .result  (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.error_code, out_r.length, out_r.opcode,
                       out_r.payload_byte};
  assign out_tlast  = out_r.eof;
  assign out_tuser  = out_r.kind;

endmodule

>>> verif/wsd_stream_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, input and result channels of the deframer. It
// keeps its own copy of the frame parser, queues the result that each accepted
// byte should cause and compares every result transaction with the oldest one.
module wsd_stream_checker import wsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic [1:0]            out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data,
  output int                    mismatch_count,
  output int                    results_due
);

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam int         REPORT_LIMIT = 40;

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_EXTLEN, ST_KEY, ST_BODY, ST_HALT
  } parse_stage_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic [31:0] length;
    logic        eof;
    logic [1:0]  code;
  } deframed_t;

  deframed_t pending_results[$];

  // Configuration as the block should see it.
  logic [31:0] max_len;
  logic        peer_client;

  // Parser state.
  parse_stage_t stage;
  logic         fin;
  logic [3:0]   opcode;
  logic         masked;
  logic [63:0]  frame_len;
  int           hdr_count;
  int           ext_needed;
  logic [31:0]  mask_key;
  logic [31:0]  body_left;
  logic [1:0]   key_pos;

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatch_count < REPORT_LIMIT)
      $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    mismatch_count++;
  endtask

  task automatic expect_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic eof, input logic [1:0] code);
    deframed_t r;
    r.kind   = kind;
    r.data   = data;
    r.opcode = opcode;
    r.length = frame_len[31:0];
    r.eof    = eof;
    r.code   = code;
    pending_results.push_back(r);
  endtask

  // The header is complete, mask key included when the frame carries one.
  task automatic finish_header();
    key_pos = 2'd0;
    if (frame_len == 64'd0) begin
      stage = ST_HDR0;
      expect_result(KIND_EMPTY, 8'd0, 1'b1, ERR_NONE);
    end else begin
      body_left = frame_len[31:0];
      stage     = ST_BODY;
    end
  endtask

  // The payload length is known: protocol checks in priority order.
  task automatic check_header();
    logic       bad;
    logic [1:0] code;
    bad  = 1'b1;
    code = ERR_NONE;
    if (frame_len > {32'd0, max_len})
      code = ERR_TOO_LONG;
    else if (masked != peer_client)
      code = ERR_MASK;
    else if (!fin && opcode != OP_CONT && opcode != OP_CLOSE &&
             opcode != OP_PING && opcode != OP_PONG)
      code = ERR_FRAGMENTED;
    else
      bad = 1'b0;
    if (bad) begin
      stage = ST_HALT;
      expect_result(KIND_ERROR, 8'd0, 1'b0, code);
    end else if (masked) begin
      hdr_count = 0;
      stage     = ST_KEY;
    end else begin
      finish_header();
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int shift;
    case (stage)
      ST_HDR0: begin
        fin       = b[7];
        opcode    = b[3:0];
        mask_key  = '0;
        frame_len = '0;
        body_left = '0;
        key_pos   = 2'd0;
        stage     = ST_HDR1;
      end
      ST_HDR1: begin
        masked    = b[7];
        frame_len = {57'd0, b[6:0]};
        if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
          ext_needed = (b[6:0] == LEN_EXT16) ? 2 : 8;
          frame_len  = '0;
          hdr_count  = 0;
          stage      = ST_EXTLEN;
        end else begin
          check_header();
        end
      end
      ST_EXTLEN: begin
        // Extended length arrives most significant byte first.
        frame_len = {frame_len[55:0], b};
        hdr_count++;
        if (hdr_count == ext_needed)
          check_header();
      end
      ST_KEY: begin
        mask_key = {mask_key[23:0], b};
        hdr_count++;
        if (hdr_count == 4)
          finish_header();
      end
      ST_BODY: begin
        // Key byte zero is the first key byte on the wire.
        shift = 24 - 8 * int'(key_pos);
        key_pos++;
        body_left--;
        expect_result(KIND_PAYLOAD, b ^ mask_key[shift +: 8], body_left == 32'd0, ERR_NONE);
        if (body_left == 32'd0)
          stage = ST_HDR0;
      end
      default: begin
        // A protocol error was seen; everything after it is dropped.
      end
    endcase
  endtask

  task automatic check_result();
    deframed_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result, kind", 64'd0, 64'(out_tuser));
      return;
    end
    want = pending_results.pop_front();
    if (out_tuser !== want.kind)
      report_mismatch("result_kind", 64'(want.kind), 64'(out_tuser));
    if (out_tdata[7:0] !== want.data)
      report_mismatch("payload_byte", 64'(want.data), 64'(out_tdata[7:0]));
    if (out_tdata[11:8] !== want.opcode)
      report_mismatch("frame_opcode", 64'(want.opcode), 64'(out_tdata[11:8]));
    if (out_tdata[43:12] !== want.length)
      report_mismatch("frame_length", 64'(want.length), 64'(out_tdata[43:12]));
    if (out_tlast !== want.eof)
      report_mismatch("end_of_frame", 64'(want.eof), 64'(out_tlast));
    if (out_tdata[45:44] !== want.code)
      report_mismatch("error_code", 64'(want.code), 64'(out_tdata[45:44]));
  endtask

  // Every transaction is taken at the rising edge it completes on.
  always @(posedge clk) begin
    if (!rst_n) begin
      max_len     = 32'd65536;
      peer_client = 1'b1;
      stage       = ST_HDR0;
      fin         = 1'b0;
      opcode      = '0;
      masked      = 1'b0;
      frame_len   = '0;
      hdr_count   = 0;
      ext_needed  = 0;
      mask_key    = '0;
      body_left   = '0;
      key_pos     = 2'd0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_LEN)
          max_len = cfg_data;
        else if (cfg_index == CFG_PEER)
          peer_client = cfg_data[0];
      end
      if (in_tvalid && in_tready)
        parse_byte(in_tdata);
      if (out_tvalid && out_tready)
        check_result();
    end
    results_due = pending_results.size();
  end

endmodule

>>> verif/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps

// Drives WebSocket frames into the deframer under several configurations and
// gives the verdict from the checker's mismatch count.
module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int                   HOLD_CYCLES   = 150;
  localparam int                   SETTLE_CYCLES = 6;
  localparam int                   TAIL_CYCLES   = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE      = 2'd3;
  localparam logic [3:0]           OP_TEXT       = 4'd1;
  localparam logic [3:0]           OP_BINARY     = 4'd2;
  localparam logic [3:0]           OP_RSVD_CTRL  = 4'hF;

  typedef enum int {FORM_7BIT, FORM_16BIT, FORM_64BIT} len_form_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]           cfg_data;
  int                    mismatch_count;
  int                    results_due;

  logic [7:0]  body_q[$];
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          hold_asked = 0;
  logic [31:0] cur_max;
  logic        cur_peer;

  websocket_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wsd_stream_checker frame_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stall patterns in segments, plus long hold-offs on request.
  initial begin
    int mode;
    int seg;
    int holds_served;
    out_tready   = 1'b0;
    holds_served = 0;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(16, 160);
      while (seg > 0) begin
        if (hold_asked != holds_served) begin
          holds_served++;
          repeat (HOLD_CYCLES) begin
            out_tready <= 1'b0;
            @(negedge clk);
          end
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 1);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (seg % 3 == 0);
        endcase
        @(negedge clk);
        seg--;
      end
    end
  end

  // Sends one stream byte in bursts with random gaps; returns at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tdata  <= b;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected result has come out.
  task automatic settle(input int extra);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_mode(input logic [31:0] max_len, input logic peer);
    logic [31:0] peer_word;
    settle(SETTLE_CYCLES);
    write_reg(CFG_MAX_LEN, max_len);
    peer_word    = $urandom();
    peer_word[0] = peer;
    write_reg(CFG_PEER, peer_word);
    cur_max  = max_len;
    cur_peer = peer;
  endtask

  // Payload bytes are mostly random, with both extremes mixed in.
  task automatic fill_body(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 15);
      body_q.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom()));
    end
  endtask

  function automatic len_form_t pick_form(input logic [63:0] len);
    int r;
    r = $urandom_range(0, 9);
    if (len < 64'd126)
      return (r < 7) ? FORM_7BIT : (r < 9) ? FORM_16BIT : FORM_64BIT;
    if (len < 64'd65536)
      return (r < 8) ? FORM_16BIT : FORM_64BIT;
    return FORM_64BIT;
  endfunction

  // Header, optional mask key, then whatever body_q holds.
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input logic [63:0] len, input len_form_t form,
                            input logic [31:0] key);
    logic [7:0] hdr1;
    hdr1[7] = masked;
    case (form)
      FORM_7BIT:  hdr1[6:0] = len[6:0];
      FORM_16BIT: hdr1[6:0] = LEN_EXT16;
      default:    hdr1[6:0] = LEN_EXT64;
    endcase
    // Reserved bits of the first header byte are random.
    send_byte({fin, 3'($urandom_range(0, 7)), op});
    send_byte(hdr1);
    if (form == FORM_16BIT) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == FORM_64BIT) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    while (body_q.size() != 0) send_byte(body_q.pop_front());
  endtask

  // A legal frame for the current setting; mostly short payloads.
  task automatic send_random_frame();
    logic [63:0] len;
    logic        fin;
    logic [3:0]  op;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 15)
      len = 64'd0;
    else if (r < 80)
      len = 64'($urandom_range(1, 12));
    else if (r < 95)
      len = 64'($urandom_range(13, 125));
    else
      len = 64'($urandom_range(126, 300));
    if (len > {32'd0, cur_max})
      len = 64'($urandom_range(0, cur_max));
    fin = ($urandom_range(0, 3) != 0);
    if (fin) begin
      op = 4'($urandom_range(0, 15));
    end else begin
      // Only continuation, close, ping and pong frames may come without FIN.
      case ($urandom_range(0, 3))
        0:       op = OP_CONT;
        1:       op = OP_CLOSE;
        2:       op = OP_PING;
        default: op = OP_PONG;
      endcase
    end
    fill_body(int'(len));
    send_frame(fin, op, cur_peer, len, pick_form(len), $urandom());
  endtask

  task automatic run_traffic(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_frame();
  endtask

  // One frame that breaks a rule, often several at once to exercise priority.
  // Everything sent after the decision point must be dropped.
  task automatic send_bad_frame();
    logic [63:0] len;
    logic        fin;
    logic        masked;
    logic [3:0]  op;
    int          r;
    fin    = 1'($urandom_range(0, 1));
    op     = 4'($urandom_range(0, 15));
    masked = 1'($urandom_range(0, 1));
    len    = 64'($urandom_range(0, (cur_max < 32'd20) ? cur_max : 32'd20));
    case (2'($urandom_range(0, 2)))
      ERR_TOO_LONG: begin
        if (cur_max == 32'hFFFF_FFFF || $urandom_range(0, 1) == 1) begin
          len[63:32] = $urandom();
          len[31:0]  = $urandom();
          if (len[63:32] == 32'd0)
            len[32] = 1'b1;
        end else begin
          len = {32'd0, cur_max} + 64'($urandom_range(1, 4));
        end
      end
      ERR_MASK: masked = !cur_peer;
      default: begin
        masked = cur_peer;
        fin    = 1'b0;
        r      = $urandom_range(1, 12);
        op     = 4'((r < 8) ? r : r + 3);
      end
    endcase
    fill_body(24);
    send_frame(fin, op, masked, len, pick_form(len), $urandom());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_max   = 32'd65536;
    cur_peer  = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: masked text frame whose key flips every bit.
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    send_frame(1'b1, OP_TEXT, 1'b1, 64'd4, FORM_7BIT, 32'hFFFF_FFFF);
    // Empty ping without FIN.
    send_frame(1'b0, OP_PING, 1'b1, 64'd0, FORM_7BIT, $urandom());
    // 16-bit length encoding of a short frame, all-zero key.
    body_q.push_back(8'hFF);
    body_q.push_back(8'h00);
    body_q.push_back(8'hA5);
    send_frame(1'b1, OP_RSVD_CTRL, 1'b1, 64'd3, FORM_16BIT, 32'h0000_0000);
    run_traffic(350);

    // No payload allowed, unmasked role; an unused register index is ignored.
    set_mode(32'd0, 1'b0);
    write_reg(CFG_NONE, $urandom());
    send_frame(1'b0, OP_CONT, 1'b0, 64'd0, FORM_64BIT, 32'd0);
    run_traffic(80);

    // Largest limit. A long frame meets a long receiver hold-off.
    set_mode(32'hFFFF_FFFF, 1'b0);
    hold_asked++;
    fill_body(200);
    send_frame(1'b1, OP_BINARY, 1'b0, 64'd200, FORM_16BIT, 32'd0);
    run_traffic(250);

    set_mode(32'd5, 1'b1);
    run_traffic(250);

    set_mode(32'd1000, 1'($urandom_range(0, 1)));
    run_traffic(400);

    // The error sticks until reset, so it can only come last.
    send_bad_frame();
    settle(TAIL_CYCLES);

    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> websocket_frame_deframer.f
sv/wsd_pkg.sv
sv/wsd_parser.sv
sv/websocket_frame_deframer.sv
verif/wsd_stream_checker.sv
verif/websocket_frame_deframer_tb.sv
